/* hw/rtl/arxks_pkg.sv */
// ----------------------------------------------------------------------------
// arxks_pkg
// Shared types and constants for the ARX keystream byte cipher.
// ----------------------------------------------------------------------------
package arxks_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ROUND_W     = 31;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned SETUP_PASSES_DEF = 64;

    localparam logic [WORD_W-1:0]  LOAD_CONST_A = 64'h98d5_7011_ef24_69a7;
    localparam logic [WORD_W-1:0]  LOAD_CONST_B = 64'h0c7e_53dd_9eb1_85bc;
    localparam logic [ROUND_W-1:0] ROUND_RESET  = 31'd2000000001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_NONCE0 = 3'd4,
        CFG_NONCE1 = 3'd5,
        CFG_ROUNDS = 3'd6
    } t_cfg_reg;

    // controller to datapath commands
    typedef struct packed {
        logic               latch;     // capture incoming data byte
        logic               load;      // load key, nonce and constants
        logic               save;      // copy working words at call start
        logic               round;     // one ARX line of a double-round
        logic               finish;    // add back and fold into stream words
        logic               emit;      // output held byte XOR keystream
        logic               emit_now;  // output incoming byte XOR keystream
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   byte_pos;
    } t_dp_cmd;

endpackage

/* hw/rtl/arxks_dp.sv */
// ----------------------------------------------------------------------------
// arxks_dp
// Datapath: working words, saved words, stream words, ARX round unit and
// output byte register.
// ----------------------------------------------------------------------------
module arxks_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  arxks_pkg::t_dp_cmd           i_cmd,
    input  logic [arxks_pkg::BYTE_W-1:0] i_data,
    input  logic [arxks_pkg::WORD_W-1:0] i_key0,
    input  logic [arxks_pkg::WORD_W-1:0] i_key1,
    input  logic [arxks_pkg::WORD_W-1:0] i_key2,
    input  logic [arxks_pkg::WORD_W-1:0] i_key3,
    input  logic [arxks_pkg::WORD_W-1:0] i_nonce0,
    input  logic [arxks_pkg::WORD_W-1:0] i_nonce1,
    output logic [arxks_pkg::BYTE_W-1:0] o_out_byte
);
    import arxks_pkg::*;

    logic [WORD_W-1:0] r_mix    [8];
    logic [WORD_W-1:0] r_save   [8];
    logic [WORD_W-1:0] r_stream [4];
    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] r_out_byte;

    logic [WORD_W-1:0] n_mix    [8];
    logic [WORD_W-1:0] sum_words[8];
    logic [WORD_W-1:0] ks_word;
    logic [BYTE_W-1:0] ks_byte;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum_words[i] = r_mix[i] + r_save[i];
        end
    end

    // one line of the double-round per phase: w[a] += w[b]; w[c] = rotl(w[c] ^ d)
    always_comb begin
        n_mix = r_mix;
        case (i_cmd.phase)
            3'd0: begin
                n_mix[0] = r_mix[0] + r_mix[7];
                n_mix[1] = rotl(r_mix[1] ^ n_mix[0], 9);
            end
            3'd1: begin
                n_mix[2] = r_mix[2] + r_mix[5];
                n_mix[3] = rotl(r_mix[3] ^ n_mix[2], 21);
            end
            3'd2: begin
                n_mix[4] = r_mix[4] + r_mix[3];
                n_mix[5] = rotl(r_mix[5] ^ n_mix[4], 12);
            end
            3'd3: begin
                n_mix[6] = r_mix[6] + r_mix[1];
                n_mix[7] = rotl(r_mix[7] ^ n_mix[6], 18);
            end
            3'd4: begin
                n_mix[1] = r_mix[1] + r_mix[0];
                n_mix[2] = rotl(r_mix[2] ^ r_mix[7], 9);
            end
            3'd5: begin
                n_mix[3] = r_mix[3] + r_mix[2];
                n_mix[4] = rotl(r_mix[4] ^ r_mix[5], 21);
            end
            3'd6: begin
                n_mix[5] = r_mix[5] + r_mix[4];
                n_mix[6] = rotl(r_mix[6] ^ r_mix[3], 12);
            end
            default: begin
                n_mix[7] = r_mix[7] + r_mix[6];
                n_mix[0] = rotl(r_mix[0] ^ r_mix[1], 18);
            end
        endcase
    end

    always_comb begin
        case (i_cmd.byte_pos[4:3])
            2'd0:    ks_word = r_stream[0];
            2'd1:    ks_word = r_stream[1];
            2'd2:    ks_word = r_stream[2];
            default: ks_word = r_stream[3];
        endcase
        // big-endian: byte 0 of a word is its top byte
        ks_byte = ks_word[(3'd7 - i_cmd.byte_pos[2:0]) * BYTE_W +: BYTE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_mix[i] <= '0;
            end
        end else if (i_cmd.load) begin
            r_mix[0] <= LOAD_CONST_A;
            r_mix[1] <= i_key0;
            r_mix[2] <= i_key2;
            r_mix[3] <= i_key1;
            r_mix[4] <= LOAD_CONST_B;
            r_mix[5] <= i_key3;
            r_mix[6] <= i_nonce0;
            r_mix[7] <= i_nonce1;
        end else if (i_cmd.round) begin
            r_mix <= n_mix;
        end else if (i_cmd.finish) begin
            r_mix <= sum_words;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save) begin
            r_save <= r_mix;
        end
        if (i_cmd.finish) begin
            for (int i = 0; i < 4; i++) begin
                r_stream[i] <= sum_words[i] ^ sum_words[i+4];
            end
        end
        if (i_cmd.latch) begin
            r_data <= i_data;
        end
        if (i_cmd.emit_now) begin
            r_out_byte <= i_data ^ ks_byte;
        end else if (i_cmd.emit) begin
            r_out_byte <= r_data ^ ks_byte;
        end
    end

    assign o_out_byte = r_out_byte;

endmodule

/* hw/rtl/arxks_ctrl.sv */
// ----------------------------------------------------------------------------
// arxks_ctrl
// Controller: sequences key setup, permutation calls and byte output, and
// keeps the keystream byte position and output valid flag.
// ----------------------------------------------------------------------------
module arxks_ctrl #(
    parameter int unsigned SETUP_PASSES = arxks_pkg::SETUP_PASSES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_start,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [arxks_pkg::ROUND_W-1:0] i_rounds,
    output arxks_pkg::t_dp_cmd            o_cmd
);
    import arxks_pkg::*;

    localparam int unsigned PASS_W = (SETUP_PASSES > 1) ? $clog2(SETUP_PASSES) : 1;
    localparam logic [PASS_W-1:0]  PASS_LAST  = PASS_W'(SETUP_PASSES - 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SAVE,
        S_ROUND,
        S_FINISH,
        S_EMIT
    } t_state;

    t_state               r_state,  n_state;
    logic [PHASE_W-1:0]   r_phase,  n_phase;
    logic [ROUND_W-1:0]   r_round,  n_round;
    logic [PASS_W-1:0]    r_pass,   n_pass;
    logic                 r_setup,  n_setup;
    logic [POS_W-1:0]     r_pos,    n_pos;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_round     = r_round;
        n_pass      = r_pass;
        n_setup     = r_setup;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.phase    = r_phase;
        o_cmd.byte_pos = r_pos;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (i_in_start) begin
                        n_state = S_LOAD;
                    end else if (r_pos == '0) begin
                        n_state = S_SAVE;
                    end else begin
                        // keystream already on hand: register the answer from the incoming byte
                        o_cmd.emit_now = 1'b1;
                        n_out_valid    = 1'b1;
                        n_pos          = r_pos + 1'b1;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_pos      = '0;
                n_setup    = 1'b1;
                n_pass     = '0;
                n_state    = S_SAVE;
            end
            S_SAVE: begin
                o_cmd.save = 1'b1;
                n_phase    = '0;
                n_round    = '0;
                n_state    = (i_rounds == '0) ? S_FINISH : S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_phase     = r_phase + 1'b1;
                if (r_phase == PHASE_LAST) begin
                    n_round = r_round + 1'b1;
                    if (n_round == i_rounds) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (r_setup) begin
                    // the last setup pass is followed by the first block's call
                    if (r_pass == PASS_LAST) begin
                        n_setup = 1'b0;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                    n_state = S_SAVE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit  = 1'b1;
                n_out_valid = 1'b1;
                n_pos       = r_pos + 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_round     <= '0;
            r_pass      <= '0;
            r_setup     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_round     <= n_round;
            r_pass      <= n_pass;
            r_setup     <= n_setup;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hw/rtl/arx_keystream_byte_cipher_top.sv */
// A byte inside a keystream block is answered in the cycle after its request.
// A block boundary adds one permutation call and an output step; a message start
// adds a load step and SETUP_PASSES more calls. Throughput: 1 byte per cycle
// inside a block while the output is free; the ARX unit does one line of a
// double-round per cycle, 8 per double-round. Reset: synchronous, active low;
// working words, byte position and registers clear, round_count to 2000000001.
// ----------------------------------------------------------------------------
// arx_keystream_byte_cipher_top
// Byte stream cipher with an ARX permutation on 64-bit words, configuration
// registers, controller and datapath.
// ----------------------------------------------------------------------------
module arx_keystream_byte_cipher_top #(
    parameter int unsigned SETUP_PASSES = arxks_pkg::SETUP_PASSES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [arxks_pkg::BYTE_W-1:0]    i_s_axis_tdata,  // [7:0] data_byte
    input  logic                            i_s_axis_tuser,  // [0] message_start
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [arxks_pkg::BYTE_W-1:0]    o_m_axis_tdata,  // [7:0] out_byte
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [arxks_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arxks_pkg::WORD_W-1:0]    i_cfg_data
);
    import arxks_pkg::*;

    logic [WORD_W-1:0]  r_key0, r_key1, r_key2, r_key3;
    logic [WORD_W-1:0]  r_nonce0, r_nonce1;
    logic [ROUND_W-1:0] r_rounds;
    t_dp_cmd            dp_cmd;
    logic               cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0   <= '0;
            r_key1   <= '0;
            r_key2   <= '0;
            r_key3   <= '0;
            r_nonce0 <= '0;
            r_nonce1 <= '0;
            r_rounds <= ROUND_RESET;
        end else if (cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_KEY0:   r_key0   <= i_cfg_data;
                CFG_KEY1:   r_key1   <= i_cfg_data;
                CFG_KEY2:   r_key2   <= i_cfg_data;
                CFG_KEY3:   r_key3   <= i_cfg_data;
                CFG_NONCE0: r_nonce0 <= i_cfg_data;
                CFG_NONCE1: r_nonce1 <= i_cfg_data;
                CFG_ROUNDS: r_rounds <= i_cfg_data[ROUND_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    arxks_ctrl #(
        .SETUP_PASSES(SETUP_PASSES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_start  (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_rounds    (r_rounds),
        .o_cmd       (dp_cmd)
    );

    arxks_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_data     (i_s_axis_tdata),
        .i_key0     (r_key0),
        .i_key1     (r_key1),
        .i_key2     (r_key2),
        .i_key3     (r_key3),
        .i_nonce0   (r_nonce0),
        .i_nonce1   (r_nonce1),
        .o_out_byte (o_m_axis_tdata)
    );

    // a new request is only taken when the output register is free or draining
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("request accepted while output register is blocked");

    // a message start always goes through key setup before any answer
    a_start_runs_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser)
            |=> (!o_s_axis_tready && !o_m_axis_tvalid))
        else $error("message start did not enter key setup");

    // output valid only rises together with a fresh datapath result
    a_valid_rises_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(dp_cmd.emit || dp_cmd.emit_now))
        else $error("output valid raised without a result");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARX keystream byte cipher. Key, nonce and round
// count settings change between phases. Each phase streams short directed
// messages or random ones with stray message starts mixed in. A local model
// of the permutation predicts every output byte, and the output stream is
// checked against it in order. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import arxks_pkg::*;

    localparam int unsigned SETUP_PASSES  = 64;
    localparam int          RANDOM_ITEMS  = 1650;
    localparam int          STALL_LIMIT   = 40000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] data;
    } t_byte_req;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 cfg_ready;

    arx_keystream_byte_cipher_top #(
        .SETUP_PASSES(SETUP_PASSES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // cipher model: registers, working words, keystream and byte position
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]  key_w   [4] = '{default: '0};
    logic [WORD_W-1:0]  nonce_w [2] = '{default: '0};
    logic [ROUND_W-1:0] rounds      = ROUND_RESET;
    logic [WORD_W-1:0]  mix     [8] = '{default: '0};
    logic [WORD_W-1:0]  strm    [4] = '{default: '0};
    logic [POS_W-1:0]   pos         = '0;

    t_byte_req         req_q[$];
    logic [BYTE_W-1:0] expected_out_q[$];
    t_byte_req         cur_req = '0;
    int                req_count  = 0;
    int                out_count  = 0;
    int                mismatches = 0;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic void run_permutation();
        logic [WORD_W-1:0] keep [8];
        keep = mix;
        for (int unsigned n = 0; n < rounds; n++) begin
            mix[0] += mix[7]; mix[1] = rotl64(mix[1] ^ mix[0], 9);
            mix[2] += mix[5]; mix[3] = rotl64(mix[3] ^ mix[2], 21);
            mix[4] += mix[3]; mix[5] = rotl64(mix[5] ^ mix[4], 12);
            mix[6] += mix[1]; mix[7] = rotl64(mix[7] ^ mix[6], 18);
            mix[1] += mix[0]; mix[2] = rotl64(mix[2] ^ mix[7], 9);
            mix[3] += mix[2]; mix[4] = rotl64(mix[4] ^ mix[5], 21);
            mix[5] += mix[4]; mix[6] = rotl64(mix[6] ^ mix[3], 12);
            mix[7] += mix[6]; mix[0] = rotl64(mix[0] ^ mix[1], 18);
        end
        foreach (mix[i]) mix[i] += keep[i];
        foreach (strm[i]) strm[i] = mix[i] ^ mix[i + 4];
    endfunction

    function automatic logic [BYTE_W-1:0] cipher_byte(input t_byte_req req);
        logic [WORD_W-1:0] word;
        if (req.start) begin
            mix[0] = LOAD_CONST_A;
            mix[4] = LOAD_CONST_B;
            mix[1] = key_w[0];
            mix[3] = key_w[1];
            mix[2] = key_w[2];
            mix[5] = key_w[3];
            mix[6] = nonce_w[0];
            mix[7] = nonce_w[1];
            repeat (SETUP_PASSES) run_permutation();
            pos = '0;
        end
        if (pos == '0) run_permutation();
        // keystream bytes come out big-endian from each word
        word = strm[pos[4:3]] >> (56 - 8 * pos[2:0]);
        pos++;
        return req.data ^ word[BYTE_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [WORD_W-1:0] val);
        case (t_cfg_reg'(idx))
            CFG_KEY0:   key_w[0]   = val;
            CFG_KEY1:   key_w[1]   = val;
            CFG_KEY2:   key_w[2]   = val;
            CFG_KEY3:   key_w[3]   = val;
            CFG_NONCE0: nonce_w[0] = val;
            CFG_NONCE1: nonce_w[1] = val;
            CFG_ROUNDS: rounds     = val[ROUND_W-1:0];
            default: ;
        endcase
    endfunction

    // mostly no gap, some short ones, a few long; calm stretches have none
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 2) begin
            calm = $urandom_range(60, 200);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    int s_gap  = 0;
    int s_calm = 0;
    bit s_offer;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            s_offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_out_q.push_back(cipher_byte(cur_req));
                s_gap   = pick_gap(s_calm);
                s_offer = 1'b0;
            end
            if (!s_offer) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    s_offer = 1'b1;
                end
            end
            s_tvalid <= s_offer;
            s_tdata  <= cur_req.data;
            s_tuser  <= cur_req.start;
        end
    end

    // ------------------------------------------------------------------------
    // output monitor and receiver stalls
    // ------------------------------------------------------------------------
    int  m_gap      = 0;
    int  m_calm     = 0;
    int  hold_left  = 0;
    int  holds_done = 0;
    bit  m_ready;
    logic [BYTE_W-1:0] want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_count++;
                if (expected_out_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected out byte %02h", m_tdata);
                end else begin
                    want = expected_out_q.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("out byte %0d: expected %02h, got %02h",
                                     out_count, want, m_tdata);
                    end
                end
                m_gap = pick_gap(m_calm);
            end
            // hold off long enough for the block to back up into its input
            if (hold_left == 0 && holds_done < 2 && req_q.size() > 40 &&
                out_count >= 300 + 600 * holds_done) begin
                hold_left = 600;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
            m_tready <= m_ready;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any accepted transfer
    // ------------------------------------------------------------------------
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    // write every register once in shuffled order, then drop valid
    task automatic write_all(input logic [WORD_W-1:0] vals [7]);
        int perm [7];
        int j, t;
        foreach (perm[i]) perm[i] = i;
        for (int i = 6; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        foreach (perm[i]) write_reg(CFG_IDX_W'(perm[i]), vals[perm[i]]);
        cfg_valid <= 1'b0;
    endtask

    // a request popped in this cycle shows in s_offer before s_tvalid rises
    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || s_offer || expected_out_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_req(input logic [BYTE_W-1:0] data, input logic start);
        t_byte_req req;
        req.data  = data;
        req.start = start;
        req_q.push_back(req);
        req_count++;
    endfunction

    function automatic void add_message(input int len);
        add_req(BYTE_W'($urandom), 1'b1);
        repeat (len - 1) add_req(BYTE_W'($urandom), 1'b0);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [WORD_W-1:0] vals [7];
        int   r, len, rc, target, directed;
        logic hb;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before any message start run on the zeroed working words;
        // high data bits above the round count field must be dropped
        write_reg(CFG_ROUNDS, 64'hffff_ffff_8000_0001);
        cfg_valid <= 1'b0;
        add_req(8'h00, 1'b0);
        add_req(8'hff, 1'b0);
        add_req(8'h5a, 1'b0);
        add_req(8'hff, 1'b1);
        add_req(8'h00, 1'b0);
        add_req(8'h80, 1'b0);
        add_req(8'h01, 1'b0);
        wait_drained();

        // all-ones key and nonce, zero rounds, and a write past the last register
        foreach (vals[i]) vals[i] = '1;
        vals[CFG_ROUNDS] = 64'hffff_ffff_0000_0000;
        write_reg(CFG_SPARE_IDX, '1);
        write_all(vals);
        add_req(8'h00, 1'b1);
        add_req(8'hff, 1'b0);
        add_req(8'h7f, 1'b0);
        add_req(8'h80, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'hff, 1'b0);
        add_req(8'h3c, 1'b1);
        add_req(8'hc3, 1'b1);
        wait_drained();

        foreach (vals[i]) vals[i] = '0;
        vals[CFG_ROUNDS] = 64'd2;
        write_all(vals);
        add_req(8'hff, 1'b1);
        add_req(8'h00, 1'b0);
        add_req(8'haa, 1'b0);
        add_req(8'h55, 1'b0);
        directed = req_count;

        while (req_count < directed + RANDOM_ITEMS) begin
            wait_drained();
            foreach (vals[i]) vals[i] = random_word();
            r = $urandom_range(0, 99);
            if (r < 10)      rc = 0;
            else if (r < 35) rc = 1;
            else if (r < 60) rc = 2;
            else if (r < 75) rc = 3;
            else if (r < 88) rc = 5;
            else if (r < 97) rc = 8;
            else             rc = 16;
            hb = 1'($urandom);
            vals[CFG_ROUNDS] = {$urandom, hb, 31'(rc)};
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE_IDX, random_word());
            write_all(vals);

            target = req_count + $urandom_range(100, 220);
            while (req_count < target) begin
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    r = $urandom_range(0, 99);
                    if (r < 15)      len = 32 * $urandom_range(1, 2);
                    else if (r < 25) len = 1;
                    else             len = $urandom_range(2, 80);
                    add_message(len);
                end else begin
                    // noise: loose bytes with an occasional stray start
                    repeat ($urandom_range(1, 10))
                        add_req(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_out_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
